// File: sv/skf_pkg.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter package
// Shared constants, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int GAIN_BITS     = 16;
    localparam logic [GAIN_BITS:0] GAIN_ONE = {1'b1, {GAIN_BITS{1'b0}}};

    localparam int DIV_STEPS = GAIN_BITS + 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [1:0] CFG_INIT_EST = 2'd0;
    localparam logic [1:0] CFG_PROC_NOISE = 2'd1;
    localparam logic [1:0] CFG_MEAS_NOISE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREDICT,
        ST_START,
        ST_DIVIDE,
        ST_MULTIPLY,
        ST_FINISH
    } skf_state_t;

endpackage

// File: sv/skf_divider.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter gain divider
// Restoring divider giving floor(dividend * 2^16 / divisor), one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module skf_divider
    import skf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          dividend,
    input  logic [32:0]          divisor,
    output logic                 done,
    output logic [GAIN_BITS:0]   quotient
);

    logic [33:0]          rem_reg;
    logic [32:0]          den_reg;
    logic [GAIN_BITS:0]   quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic        ge;
    logic [33:0] rem_sub;

    assign ge      = rem_reg >= {1'b0, den_reg};
    assign rem_sub = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {2'b00, dividend};
            den_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= {rem_sub[32:0], 1'b0};
            quo_reg <= {quo_reg[GAIN_BITS-1:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: sv/scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter
// One-dimensional constant-state Kalman filter on signed Q16.16 samples.
// ----------------------------------------------------------------------------
// Each measurement beat passes through the predict, start, divide, multiply
// and finish states before the next beat can be taken, the divide state running
// the bit-serial gain divider (one quotient bit per cycle); the block is not
// ready meanwhile. The result is held in an output register, so a new
// measurement is accepted while the previous result still waits. Writing any
// configuration register reloads the estimate and sets the covariance back to one.
module scalar_kalman_filter
    import skf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [31:0]    measurement,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [31:0]    filtered_estimate,
    output logic [GAIN_BITS:0]    kalman_gain
);

    localparam logic [31:0] COV_ONE = 32'(1) << FRAC_BITS;

    skf_state_t state_reg, state_next;

    logic [31:0]        init_est_reg;
    logic [30:0]        q_reg;
    logic [30:0]        r_reg;
    logic [31:0]        est_reg;
    logic [31:0]        cov_reg;
    logic [31:0]        meas_reg;
    logic [31:0]        p_reg;
    logic [GAIN_BITS:0] gain_reg;
    logic signed [50:0] prod_reg;
    logic [48:0]        covp_reg;
    logic               out_valid_reg;
    logic [31:0]        out_est_reg;
    logic [GAIN_BITS:0] out_gain_reg;

    logic               div_start;
    logic               div_done;
    logic [GAIN_BITS:0] div_quo;
    logic               commit;
    logic               cfg_hit;

    logic [32:0]        p_sum;
    logic [31:0]        p_sat;
    logic [32:0]        den;
    logic signed [32:0] diff;
    logic signed [50:0] rounded;
    logic signed [34:0] est_sum;
    logic [31:0]        est_new;

    assign p_sum = {1'b0, cov_reg} + {2'b00, q_reg};
    assign p_sat = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
    assign den   = {1'b0, p_reg} + {2'b00, r_reg};
    assign diff  = $signed({meas_reg[31], meas_reg}) - $signed({est_reg[31], est_reg});

    assign rounded = prod_reg + 51'sd32768;
    assign est_sum = $signed({{3{est_reg[31]}}, est_reg}) + $signed(rounded[50:16]);

    always_comb
    begin
        if (est_sum > 35'sh0_7FFF_FFFF)
        begin
            est_new = 32'h7FFF_FFFF;
        end
        else if (est_sum < -35'sh0_8000_0000)
        begin
            est_new = 32'h8000_0000;
        end
        else
        begin
            est_new = est_sum[31:0];
        end
    end

    assign cfg_hit = cfg_we && (cfg_index == CFG_INIT_EST || cfg_index == CFG_PROC_NOISE
                                || cfg_index == CFG_MEAS_NOISE);

    skf_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (p_reg),
        .divisor  (den),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_PREDICT;
                end
            end
            ST_PREDICT:  state_next = ST_START;
            ST_START:    state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_MULTIPLY;
                end
            end
            ST_MULTIPLY: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        commit    = 1'b0;
        case (state_reg)
            ST_IDLE:   in_ready  = 1'b1;
            ST_START:  div_start = 1'b1;
            ST_FINISH: commit    = !out_valid_reg || out_ready;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            init_est_reg  <= '0;
            q_reg         <= 31'd655;
            r_reg         <= 31'd6554;
            est_reg       <= '0;
            cov_reg       <= COV_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_hit)
            begin
                case (cfg_index)
                    CFG_INIT_EST:   init_est_reg <= cfg_data;
                    CFG_PROC_NOISE: q_reg        <= cfg_data[30:0];
                    CFG_MEAS_NOISE: r_reg        <= cfg_data[30:0];
                    default:        init_est_reg <= init_est_reg;
                endcase
                est_reg <= (cfg_index == CFG_INIT_EST) ? cfg_data : init_est_reg;
                cov_reg <= COV_ONE;
            end
            else if (commit)
            begin
                est_reg <= est_new;
                cov_reg <= covp_reg[GAIN_BITS+31:GAIN_BITS];
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            meas_reg <= measurement;
        end
        if (state_reg == ST_PREDICT)
        begin
            p_reg <= p_sat;
        end
        if (state_reg == ST_DIVIDE && div_done)
        begin
            gain_reg <= (div_quo > GAIN_ONE) ? GAIN_ONE : div_quo;
        end
        if (state_reg == ST_MULTIPLY)
        begin
            prod_reg <= 51'(diff) * 51'($signed({1'b0, gain_reg}));
            covp_reg <= 49'(p_reg) * 49'(GAIN_ONE - gain_reg);
        end
        if (commit)
        begin
            out_est_reg  <= est_new;
            out_gain_reg <= gain_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign filtered_estimate = out_est_reg;
    assign kalman_gain       = out_gain_reg;

endmodule

// File: sv/skf_checker.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module skf_checker
    import skf_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic signed [31:0]    filtered_estimate,
    input logic [GAIN_BITS:0]    kalman_gain
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(filtered_estimate)
                                    && $stable(kalman_gain))
        else $error("result beat changed while stalled");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kalman_gain <= GAIN_ONE)
        else $error("gain above one");

    // The block is busy after taking a measurement and holds in_ready low.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("measurement accepted while busy");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (.*);

// File: test/kalman_update_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kalman update checker
// Watches the configuration port and both streaming channels of the scalar
// Kalman filter. It keeps its own estimate, covariance and register copies,
// works out the update that each accepted measurement beat should produce and
// compares every result beat with the oldest outstanding update.
// ----------------------------------------------------------------------------
module kalman_update_checker
    import skf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic signed [31:0]    measurement,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic signed [31:0]    filtered_estimate,
    input  logic [GAIN_BITS:0]    kalman_gain,
    output int                    error_count,
    output int                    pending
);

    localparam logic [31:0] COV_ONE          = 32'd1 << FRAC_BITS_DEF;
    localparam logic [30:0] PROC_NOISE_RESET = 31'd655;
    localparam logic [30:0] MEAS_NOISE_RESET = 31'd6554;
    localparam logic [63:0] COV_MAX          = 64'h0000_0000_FFFF_FFFF;
    localparam longint      ROUND_HALF       = longint'(1) <<< (GAIN_BITS - 1);
    localparam longint      EST_MAX          = 64'sd2147483647;
    localparam longint      EST_MIN          = -64'sd2147483648;
    localparam int          MAX_REPORTS      = 200;

    typedef struct packed {
        logic signed [31:0]  estimate;
        logic [GAIN_BITS:0]  gain;
    } kalman_update_t;

    kalman_update_t      expected_updates[$];
    logic signed [31:0]  initial_estimate_reg;
    logic [30:0]         process_noise_reg;
    logic [30:0]         measurement_noise_reg;
    logic signed [31:0]  estimate_state;
    logic [31:0]         covariance_state;
    int                  mismatches;

    function automatic void apply_register_write(input logic [1:0] index,
                                                 input logic [31:0] data);
        bit reload;
        reload = 1'b1;
        case (index)
            CFG_INIT_EST:   initial_estimate_reg = data;
            CFG_PROC_NOISE: process_noise_reg = data[30:0];
            CFG_MEAS_NOISE: measurement_noise_reg = data[30:0];
            default:        reload = 1'b0;
        endcase
        if (reload)
        begin
            estimate_state = initial_estimate_reg;
            covariance_state = COV_ONE;
        end
    endfunction

    function automatic kalman_update_t predict_update(input logic signed [31:0] sample);
        kalman_update_t upd;
        logic [63:0]    prior;
        logic [63:0]    denom;
        logic [63:0]    gain_w;
        logic [63:0]    cov_next;
        longint         diff;
        longint         correction;
        longint         next_est;
        prior = {32'd0, covariance_state} + {33'd0, process_noise_reg};
        if (prior > COV_MAX)
            prior = COV_MAX;
        denom = prior + {33'd0, measurement_noise_reg};
        if (denom == 64'd0)
            gain_w = 64'(GAIN_ONE);
        else
            gain_w = (prior << GAIN_BITS) / denom;
        if (gain_w > 64'(GAIN_ONE))
            gain_w = 64'(GAIN_ONE);
        diff = longint'(sample) - longint'(estimate_state);
        correction = (diff * longint'(gain_w) + ROUND_HALF) >>> GAIN_BITS;
        next_est = longint'(estimate_state) + correction;
        if (next_est > EST_MAX)
            next_est = EST_MAX;
        if (next_est < EST_MIN)
            next_est = EST_MIN;
        estimate_state = next_est[31:0];
        cov_next = (prior * (64'(GAIN_ONE) - gain_w)) >> GAIN_BITS;
        covariance_state = cov_next[31:0];
        upd.estimate = estimate_state;
        upd.gain = gain_w[GAIN_BITS:0];
        return upd;
    endfunction

    task automatic report_mismatch(input string field, input longint want, input longint got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        kalman_update_t want;
        if (!rst_n)
        begin
            initial_estimate_reg = '0;
            process_noise_reg = PROC_NOISE_RESET;
            measurement_noise_reg = MEAS_NOISE_RESET;
            estimate_state = '0;
            covariance_state = COV_ONE;
            expected_updates.delete();
            mismatches = 0;
            error_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                apply_register_write(cfg_index, cfg_data);
            if (out_valid && out_ready)
            begin
                if (expected_updates.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result beat with nothing expected, actual %0d / %0d",
                                 $time, filtered_estimate, kalman_gain);
                end
                else
                begin
                    want = expected_updates.pop_front();
                    if (filtered_estimate !== want.estimate)
                        report_mismatch("filtered_estimate", longint'(want.estimate),
                                        longint'(filtered_estimate));
                    if (kalman_gain !== want.gain)
                        report_mismatch("kalman_gain", longint'(want.gain),
                                        longint'(kalman_gain));
                end
            end
            if (in_valid && in_ready)
                expected_updates.push_back(predict_update(measurement));
            error_count <= mismatches;
            pending <= expected_updates.size();
        end
    end

endmodule

// File: test/tb_scalar_kalman_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scalar Kalman filter testbench
// Drives measurement beats and register writes into the filter, with random
// idle bursts on both channels, a long output hold-off and drained pauses.
// A directed opening covers field extremes, zero noise, saturated noise and
// an unused register index; random phases follow with fresh settings each.
// ----------------------------------------------------------------------------
module tb_scalar_kalman_filter;
    import skf_pkg::*;

    localparam logic [1:0] CFG_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS  = 1430;
    localparam int         QUIET_ITEMS   = 150;
    localparam int         DRAIN_CYCLES  = 30;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         STALL_LIMIT   = 3000;
    localparam int         PRESSURE_PHASE = 3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [1:0]           cfg_index;
    logic [31:0]          cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [31:0]   measurement;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [31:0]   filtered_estimate;
    logic [GAIN_BITS:0]   kalman_gain;
    int                   error_count;
    int                   pending;

    int unsigned          send_idle_pct = 0;
    int unsigned          recv_idle_pct = 0;
    bit                   quiet = 1'b0;
    bit                   hold_pending = 1'b0;
    int                   stall_cycles = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    scalar_kalman_filter dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .measurement       (measurement),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .filtered_estimate (filtered_estimate),
        .kalman_gain       (kalman_gain)
    );

    kalman_update_checker update_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .measurement       (measurement),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .filtered_estimate (filtered_estimate),
        .kalman_gain       (kalman_gain),
        .error_count       (error_count),
        .pending           (pending)
    );

    function automatic int pick_gap();
        if (quiet || $urandom_range(0, 99) >= send_idle_pct)
            return 0;
        return $urandom_range(1, 17);
    endfunction

    function automatic logic [31:0] pick_measurement(input logic [31:0] centre);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return centre + $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_noise();
        logic [31:0]  value;
        int unsigned  sel;
        sel = $urandom_range(0, 4);
        case (sel)
            0:       value = 32'd0;
            1:       value = 32'h7FFF_FFFF;
            2:       value = $urandom_range(0, 32'h0002_0000);
            3:       value = $urandom_range(0, 32'h0100_0000);
            default: value = $urandom;
        endcase
        value[31] = $urandom_range(0, 1);
        return value;
    endfunction

    function automatic logic [31:0] pick_initial();
        int unsigned sel;
        sel = $urandom_range(0, 5);
        case (sel)
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_measurement(input logic [31:0] value, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        measurement <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_registers(input logic [31:0] init_val, input logic [31:0] q_val,
                                   input logic [31:0] r_val, input logic [2:0] mask,
                                   input bit stray);
        if (mask[0])
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_INIT_EST;
            cfg_data <= init_val;
            @(posedge clk);
        end
        if (mask[1])
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_PROC_NOISE;
            cfg_data <= q_val;
            @(posedge clk);
        end
        if (mask[2])
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_MEAS_NOISE;
            cfg_data <= r_val;
            @(posedge clk);
        end
        if (stray)
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_UNUSED;
            cfg_data <= $urandom;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 99) < recv_idle_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[scalar_kalman_filter] ERROR");
            $finish;
        end
    end

    initial
    begin
        int           items_left;
        int           run_len;
        int           phase;
        logic [31:0]  centre;

        cfg_we <= 1'b0;
        cfg_index <= CFG_INIT_EST;
        cfg_data <= '0;
        in_valid <= 1'b0;
        measurement <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_measurement(32'h0000_0000, 0);
        send_measurement(32'h7FFF_FFFF, 0);
        send_measurement(32'h8000_0000, 0);
        send_measurement(32'hFFFF_FFFF, 0);
        send_measurement(32'h0001_0000, 0);
        send_measurement(32'h0000_0001, 0);

        // With both noise terms at zero the covariance collapses and the
        // denominator of the gain becomes zero on the following beat.
        settle();
        write_registers(32'h7FFF_FFFF, 32'd0, 32'd0, 3'b111, 1'b0);
        send_measurement(32'h8000_0000, 0);
        send_measurement(32'h7FFF_FFFF, 0);
        send_measurement(32'h0000_0000, 0);

        settle();
        write_registers(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b111, 1'b0);
        send_measurement(32'h7FFF_FFFF, 0);
        send_measurement(32'h8000_0000, 0);
        send_measurement(32'h7FFF_FFFF, 0);

        settle();
        write_registers('0, '0, '0, 3'b000, 1'b1);
        send_measurement(32'h0000_0000, 0);
        send_measurement(32'hFFFF_0000, 0);

        settle();
        write_registers('0, 32'd0, '0, 3'b010, 1'b0);
        send_measurement(32'h7FFF_FFFF, 0);
        send_measurement(32'h8000_0000, 0);
        send_measurement(32'h0000_0001, 0);

        settle();
        write_registers(32'hFFFF_0000, 32'h7FFF_FFFF, 32'h0000_0001, 3'b111, 1'b0);
        send_measurement(32'h1234_5678, 0);
        send_measurement(32'h8000_0000, 0);

        items_left = RANDOM_ITEMS;
        phase = 0;
        while (items_left > 0)
        begin
            run_len = $urandom_range(30, 120);
            if (run_len > items_left)
                run_len = items_left;
            settle();
            write_registers(pick_initial(), pick_noise(), pick_noise(),
                            3'($urandom_range(1, 7)), $urandom_range(0, 7) == 0);
            send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
            recv_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
            if (items_left <= QUIET_ITEMS)
                quiet = 1'b1;
            if (phase == PRESSURE_PHASE)
            begin
                send_idle_pct = 0;
                hold_pending = 1'b1;
            end
            centre = $urandom;
            repeat (run_len)
            begin
                if ($urandom_range(0, 15) == 0)
                    centre = $urandom;
                send_measurement(pick_measurement(centre), pick_gap());
            end
            items_left -= run_len;
            phase++;
        end

        settle();
        if (error_count == 0 && pending == 0)
            $display("[scalar_kalman_filter] OK");
        else
            $display("[scalar_kalman_filter] ERROR");
        $finish;
    end

endmodule

// File: scalar_kalman_filter.f
sv/skf_pkg.sv
sv/skf_divider.sv
sv/scalar_kalman_filter.sv
sv/skf_checker.sv
test/kalman_update_checker.sv
test/tb_scalar_kalman_filter.sv
